### hw/rtl/cprf_pkg.sv
// Shared types and constants for the character picture rotate/frame block.
package cprf_pkg;

  localparam int MAX_DIM = 128;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OPERATION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CHAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 2'd3;

  localparam logic [2:0] OP_PLAIN     = 3'd0;
  localparam logic [2:0] OP_ROT_RIGHT = 3'd1;
  localparam logic [2:0] OP_ROT_LEFT  = 3'd2;
  localparam logic [2:0] OP_FRAME     = 3'd3;
  localparam logic [2:0] OP_DOT       = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] FRAME_CHAR_RST = 8'd43;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [7:0]       pixel_in;
  } pic_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       in_range;
  } pic_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
  } dp_sts_t;

endpackage

### hw/rtl/cprf_ctrl.sv
// Controller state machine: sequences store reads and the result strobe.
module cprf_ctrl import cprf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        // writes finish at the accept edge; only reads go on
        if (start && sts.is_read) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_SHOW;
      ST_SHOW:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept      = 1'b0;
    cmd.load_result = 1'b0;
    busy            = 1'b0;
    done            = 1'b0;
    case (state)
      ST_IDLE:  cmd.accept = start;
      ST_FETCH: begin
        busy            = 1'b1;
        cmd.load_result = 1'b1;
      end
      ST_SHOW: begin
        busy = 1'b1;
        done = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### hw/rtl/cprf_datapath.sv
// Datapath: configuration registers, picture store, address mapping and result register.
module cprf_datapath import cprf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pic_in_t               item,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  output pic_out_t              result
);

  logic [2:0]       operation;
  logic [7:0]       frame_char;
  logic [7:0]       source_rows;
  logic [7:0]       source_cols;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  logic [DIM_W-1:0]  rows_eff, cols_eff, out_rows, out_cols;
  logic [DIM_W-1:0]  r_ext, c_ext, src_r, src_c;
  logic              in_rng, on_border, wr_ok;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  logic       in_range_q, frame_q, dot_q;
  logic [7:0] pixel_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= OP_PLAIN;
      frame_char  <= FRAME_CHAR_RST;
      source_rows <= 8'(MAX_DIM);
      source_cols <= 8'(MAX_DIM);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OPERATION:   operation   <= cfg_data[2:0];
        REG_FRAME_CHAR:  frame_char  <= cfg_data;
        REG_SOURCE_ROWS: source_rows <= cfg_data;
        REG_SOURCE_COLS: source_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // saturate dimensions above the store size
    rows_eff = (source_rows > 8'(MAX_DIM)) ? DIM_MAX : DIM_W'(source_rows);
    cols_eff = (source_cols > 8'(MAX_DIM)) ? DIM_MAX : DIM_W'(source_cols);
    r_ext    = {1'b0, item.row};
    c_ext    = {1'b0, item.col};

    if (operation == OP_ROT_RIGHT || operation == OP_ROT_LEFT) begin
      out_rows = cols_eff;
      out_cols = rows_eff;
    end else begin
      out_rows = rows_eff;
      out_cols = cols_eff;
    end
    in_rng = (r_ext < out_rows) && (c_ext < out_cols);

    case (operation)
      OP_ROT_RIGHT: begin
        src_r = rows_eff - DIM_W'(1) - c_ext;
        src_c = r_ext;
      end
      OP_ROT_LEFT: begin
        src_r = c_ext;
        src_c = cols_eff - DIM_W'(1) - r_ext;
      end
      default: begin
        src_r = r_ext;
        src_c = c_ext;
      end
    endcase
    rd_addr = {src_r[IDX_W-1:0], src_c[IDX_W-1:0]};

    on_border = (item.row == '0) || (r_ext == rows_eff - DIM_W'(1)) ||
                (item.col == '0) || (c_ext == cols_eff - DIM_W'(1));

    wr_ok   = (item.mode == MODE_WRITE) && (r_ext < rows_eff) && (c_ext < cols_eff);
    wr_addr = {item.row, item.col};
  end

  assign sts.is_read = (item.mode == MODE_READ);

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok) begin
      mem[wr_addr] <= item.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // capture the per-read decisions alongside the store read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_range_q <= in_rng;
      frame_q    <= (operation == OP_FRAME) && on_border;
      dot_q      <= (operation == OP_DOT);
    end
  end

  always_comb begin
    if (!in_range_q) begin
      pixel_val = 8'd0;
    end else if (frame_q) begin
      pixel_val = frame_char;
    end else if (dot_q && rd_data == CH_SPACE) begin
      pixel_val = CH_DOT;
    end else begin
      pixel_val = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result.pixel_out <= pixel_val;
      result.in_range  <= in_range_q;
    end
  end

endmodule

### hw/rtl/char_picture_rotate_frame.sv
// Top level of the character picture store with rotated and framed read-out.
//
// Command channel: drive item with start high while busy is low; the item
// is taken at that edge. A write item (mode 0) stores pixel_in at row/col of
// the source picture and finishes at the accept edge; busy stays low, so a
// write can be issued every cycle. A read item (mode 1) maps the output
// coordinates through the configured operation, reads the picture store,
// and shows the result on result with done high for exactly one cycle, in
// ST_SHOW after ST_FETCH. busy is high in both states, so a new read is
// not taken until the last one is through. The store's registered read port
// and the result register lie between the accept edge and the result.
// The receiver cannot stall; a result is gone after its done cycle.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// in the cycle; change registers only while the block is idle.
// Reset (rst, synchronous) returns the controller to idle and the registers
// to plain operation, frame '+' and 128 x 128. The picture store is not
// cleared: read only pixels that have been written.
module char_picture_rotate_frame import cprf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pic_in_t               item,
  output logic                  done,
  output pic_out_t              result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     busy_int;

  assign busy = busy_int;

  cprf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy_int),
    .done  (done)
  );

  cprf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

### hw/rtl/cprf_checker.sv
// Port-level checker for the picture block, bound to the top level.
module cprf_checker import cprf_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input pic_in_t  item,
  input logic     done,
  input pic_out_t result
);

  logic read_xfer;
  assign read_xfer = start && !busy && (item.mode == MODE_READ);

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    read_xfer |=> busy)
    else $error("busy not raised after read transfer");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    read_xfer |-> ##2 done)
    else $error("read result not shown two cycles after transfer");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.in_range) |-> (result.pixel_out == 8'd0))
    else $error("out-of-range read returned nonzero pixel");

endmodule

bind char_picture_rotate_frame cprf_checker u_cprf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
